// ----- design/sorted_key_table_core_defines.svh -----
// Assertion macros shared by the sorted key table RTL.
// Used by files that carry concurrent assertions; no other dependencies.
`ifndef SORTED_KEY_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_TABLE_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SKT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define SKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- design/skt_pkg.sv -----
// Package for the sorted key table: widths, request and status codes, controller
// states, the controller-to-datapath command struct and the status struct. No dependencies.
`default_nettype none
package skt_pkg;
	localparam int CAPACITY   = 256;
	localparam int KEY_WIDTH  = 32;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_ITER   = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_ITER_END  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_ITER_RD,
		S_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic    load_req;
		logic    search_step;
		logic    shift_step;
		logic    iter_read;
		logic    finish;
		status_t status;
	} skt_cmd_t;

	typedef struct packed {
		logic search_done;
		logic hit;
		logic shift_done;
		logic full;
		logic iter_end;
	} skt_stat_t;
endpackage
`default_nettype wire

// ----- design/skt_datapath.sv -----
// Datapath of the sorted key table: key and data memories, search pointer,
// shift engine, count and cursor. Depends on skt_pkg.
`default_nettype none
module skt_datapath import skt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  compare_signed,
	input  wire skt_cmd_t              cmd,
	input  wire logic [1:0]            req_type,
	input  wire logic [KEY_WIDTH-1:0]  key,
	input  wire logic [DATA_WIDTH-1:0] data_in,
	output skt_stat_t                  stat,
	output logic [DATA_WIDTH-1:0]      res_data_q,
	output logic [CNT_W-1:0]           fill_after
);
	logic [KEY_WIDTH-1:0]  key_mem [CAPACITY];
	logic [DATA_WIDTH-1:0] data_mem [CAPACITY];
	logic [KEY_WIDTH-1:0]  rd_key_q;
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic [CNT_W-1:0]      fill_q;
	logic [CNT_W-1:0]      ptr_q;
	logic [CNT_W-1:0]      sh_q;
	logic [CNT_W-1:0]      iter_q;
	logic [CNT_W-1:0]      rd_addr;
	logic                  rd_valid_q;
	logic                  hit_q;
	logic                  is_ins_q;
	logic [KEY_WIDTH-1:0]  key_q;
	logic [DATA_WIDTH-1:0] din_q;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [KEY_WIDTH-1:0]  wr_key;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [KEY_WIDTH-1:0]  flip;
	logic                  less;

	assign flip = {compare_signed, {(KEY_WIDTH-1){1'b0}}};
	assign less = (rd_key_q ^ flip) < (key_q ^ flip);

	// Search reads ptr; shift reads the neighbor of the slot being written.
	always_comb begin
		rd_addr = ptr_q;
		if (cmd.shift_step)
			rd_addr = is_ins_q ? sh_q - CNT_W'(2) : sh_q + CNT_W'(1);
		else if (cmd.iter_read)
			rd_addr = iter_q;
	end

	always_ff @(posedge clk) begin
		rd_key_q  <= key_mem[rd_addr[IDX_W-1:0]];
		rd_data_q <= data_mem[rd_addr[IDX_W-1:0]];
		if (wr_en) begin
			key_mem[wr_addr]  <= wr_key;
			data_mem[wr_addr] <= wr_data;
		end
	end

	// Search: each entry is addressed, then compared once its read word is registered.
	// Shift: entry at sh_q-1 (insert) or sh_q (delete) is written from the read word.
	always_comb begin
		stat.full        = fill_q == CNT_W'(CAPACITY);
		stat.iter_end    = iter_q >= fill_q;
		stat.search_done = 1'b0;
		stat.hit         = 1'b0;
		if (ptr_q >= fill_q)
			stat.search_done = 1'b1;
		else if (rd_valid_q) begin
			if (is_ins_q ? !less : (rd_key_q == key_q)) begin
				stat.search_done = 1'b1;
				stat.hit         = 1'b1;
			end
		end
		stat.shift_done = is_ins_q ? (sh_q <= ptr_q + CNT_W'(1))
		                           : (sh_q + CNT_W'(1) >= fill_q);
		wr_en   = 1'b0;
		wr_addr = ptr_q[IDX_W-1:0];
		wr_key  = key_q;
		wr_data = din_q;
		if (cmd.shift_step && rd_valid_q) begin
			wr_en = 1'b1;
			wr_key = rd_key_q;
			wr_data = rd_data_q;
			wr_addr = is_ins_q ? IDX_W'(sh_q - CNT_W'(1)) : sh_q[IDX_W-1:0];
		end else if (cmd.finish && is_ins_q && cmd.status == ST_OK) begin
			wr_en = 1'b1;
		end
	end

	// Count as it stands once the current request completes.
	always_comb begin
		fill_after = fill_q;
		if (cmd.finish && cmd.status == ST_OK) begin
			if (is_ins_q)
				fill_after = fill_q + CNT_W'(1);
			else if (hit_q)
				fill_after = fill_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			iter_q     <= '0;
			ptr_q      <= '0;
			sh_q       <= '0;
			rd_valid_q <= 1'b0;
			hit_q      <= 1'b0;
			is_ins_q   <= 1'b0;
		end else begin
			rd_valid_q <= 1'b0;
			if (cmd.load_req) begin
				is_ins_q <= req_type == REQ_INSERT;
				ptr_q    <= '0;
				hit_q    <= 1'b0;
				if (req_type != REQ_ITER)
					iter_q <= '0;
				if (req_type == REQ_CLEAR)
					fill_q <= '0;
			end
			if (cmd.search_step) begin
				if (stat.search_done) begin
					hit_q <= stat.hit;
					sh_q  <= is_ins_q ? fill_q + CNT_W'(1) : ptr_q;
				end else if (rd_valid_q)
					ptr_q <= ptr_q + CNT_W'(1);
				else
					rd_valid_q <= 1'b1;
			end
			if (cmd.shift_step) begin
				if (rd_valid_q)
					sh_q <= is_ins_q ? sh_q - CNT_W'(1) : sh_q + CNT_W'(1);
				else
					rd_valid_q <= 1'b1;
			end
			if (cmd.iter_read) begin
				rd_valid_q <= 1'b1;
				if (rd_valid_q)
					iter_q <= iter_q + CNT_W'(1);
			end
			if (cmd.finish) begin
				fill_q <= fill_after;
				if (cmd.status == ST_ITER_END)
					iter_q <= '0;
			end
		end
	end

	// Result data register; the deleted word is captured when the search hits, the iterated word when its read returns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_data_q <= '0;
		end else if (cmd.load_req) begin
			res_data_q <= '0;
		end else if (cmd.search_step && stat.hit && !is_ins_q) begin
			res_data_q <= rd_data_q;
		end else if (cmd.iter_read && rd_valid_q) begin
			res_data_q <= rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			key_q <= key;
			din_q <= data_in;
		end
	end
endmodule
`default_nettype wire

// ----- design/skt_ctrl.sv -----
// Controller state machine of the sorted key table.
// Depends on skt_pkg and the assertion macros header.
`default_nettype none
`include "sorted_key_table_core_defines.svh"
module skt_ctrl import skt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_fire,
	input  wire logic [1:0] req_type,
	input  wire skt_stat_t stat,
	input  wire logic      out_free,
	output logic           busy,
	output skt_cmd_t       cmd,
	output logic           done
);
	ctrl_state_t state_q, state_d;
	req_t        req_q;
	logic        rd_wait_q;
	status_t     st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			req_q     <= REQ_INSERT;
			st_q      <= ST_OK;
			rd_wait_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (in_fire)
				req_q <= req_t'(req_type);
			rd_wait_q <= state_q == S_ITER_RD && !rd_wait_q;
		end
	end

	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd     = '0;
		cmd.status = st_q;
		done    = 1'b0;
		busy    = state_q != S_IDLE;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load_req = 1'b1;
					st_d = ST_OK;
					case (req_t'(req_type))
						REQ_INSERT: state_d = S_SEARCH;
						REQ_DELETE: state_d = S_SEARCH;
						REQ_ITER:   state_d = S_ITER_RD;
						default:    state_d = S_RESULT;
					endcase
				end
			end
			S_SEARCH: begin
				if (req_q == REQ_INSERT && stat.full) begin
					st_d = ST_FULL;
					state_d = S_RESULT;
				end else begin
					cmd.search_step = 1'b1;
					if (stat.search_done) begin
						if (req_q == REQ_DELETE && !stat.hit) begin
							st_d = ST_NOT_FOUND;
							state_d = S_RESULT;
						end else
							state_d = S_SHIFT;
					end
				end
			end
			S_SHIFT: begin
				if (stat.shift_done)
					state_d = S_RESULT;
				else
					cmd.shift_step = 1'b1;
			end
			S_ITER_RD: begin
				if (stat.iter_end) begin
					st_d = ST_ITER_END;
					state_d = S_RESULT;
				end else begin
					cmd.iter_read = 1'b1;
					if (rd_wait_q)
						state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					cmd.finish = req_q != REQ_ITER || st_q == ST_ITER_END;
					cmd.status = st_q;
					done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	`SKT_ASSERT_IMPL(a_load_idle, clk, arst_n, cmd.load_req, state_q == S_IDLE, "load outside idle")
	`SKT_ASSERT_IMPL(a_one_op, clk, arst_n, 1'b1, $onehot0({cmd.search_step, cmd.shift_step, cmd.iter_read, done}), "overlapping commands")
	`SKT_ASSERT_NEXT(a_done_idle, clk, arst_n, done, state_q == S_IDLE, "no return to idle")
endmodule
`default_nettype wire

// ----- design/sorted_key_table_core.sv -----
// Top level of the sorted key table: stream ports, configuration register,
// output register. Depends on skt_pkg, skt_ctrl and skt_datapath.
//
// Usage: requests arrive on s_axis (tdata = req_type, key, data_in from bit 0).
// Each request gives exactly one result on m_axis (tdata = status, data_out,
// entry_count from bit 0). One request is worked at a time; s_axis_tready is
// high only while the controller is idle. A clear or an insert into a full
// table touches no memory; an iterate reads one word; a delete or an insert
// searches entry by entry, each compare waiting on the registered read of
// the key and data memories, which have a single read port, and an insert
// or a hit delete then moves each later entry by one slot. The result sits
// in an output register; a stalled receiver holds it there and the
// controller waits before completing the next transfer.
// Reset empties the table, rewinds the cursor and clears compare_signed;
// memory contents need no clearing because only entries below the count
// are ever read.
`default_nettype none
module sorted_key_table_core import skt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,  // req_type[1:0], key[33:2], data_in[65:34]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata   // status[1:0], data_out[33:2], entry_count[42:34]
);
	logic                  cmp_signed_q;
	logic                  busy;
	logic                  done;
	logic                  in_fire;
	logic                  out_free;
	skt_cmd_t              cmd;
	skt_stat_t             stat;
	logic [DATA_WIDTH-1:0] res_data_q;
	logic [CNT_W-1:0]      fill_after;
	logic [47:0]           out_q;
	logic                  out_valid_q;

	assign s_axis_tready = !busy;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cmp_signed_q <= 1'b0;
		else if (cfg_we)
			cmp_signed_q <= cfg_wdata;
	end

	skt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.req_type(s_axis_tdata[1:0]), .stat(stat), .out_free(out_free),
		.busy(busy), .cmd(cmd), .done(done)
	);

	// The datapath reports the count as it will stand after this request.
	skt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .compare_signed(cmp_signed_q), .cmd(cmd),
		.req_type(s_axis_tdata[1:0]), .key(s_axis_tdata[33:2]),
		.data_in(s_axis_tdata[65:34]), .stat(stat),
		.res_data_q(res_data_q), .fill_after(fill_after)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done)
			out_q <= {5'd0, fill_after, res_data_q, cmd.status};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
endmodule
`default_nettype wire

// ----- tb/sorted_key_table_core_test.sv -----
// Testbench for sorted_key_table_core: random and directed table requests,
// checked against a behavioral sorted table. Depends on skt_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none
module sorted_key_table_core_test;
	import skt_pkg::*;

	typedef struct packed {
		req_t        kind;
		logic [31:0] key;
		logic [31:0] data;
	} table_req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] data;
		logic [8:0]  count;
	} table_resp_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;

	sorted_key_table_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
	);

	// Behavioral copy of the table.
	logic [31:0] tbl_key [CAPACITY];
	logic [31:0] tbl_data [CAPACITY];
	int          tbl_fill;
	int          tbl_cursor;
	logic        cmp_signed;

	table_req_t  pending_reqs[$];
	table_resp_t expected_resps[$];
	int          errors;
	int          sent;
	int          got;
	int          send_idle_pct;
	int          recv_stall_pct;

	function automatic logic [32:0] key_order(logic [31:0] k);
		return {1'b0, k ^ {cmp_signed, 31'd0}};
	endfunction

	// Apply one request to the table copy and return the expected response.
	function automatic table_resp_t table_apply(table_req_t r);
		table_resp_t rsp;
		int          pos;
		rsp = '{ST_OK, 32'd0, 9'd0};
		case (r.kind)
			REQ_INSERT: begin
				tbl_cursor = 0;
				if (tbl_fill >= CAPACITY) begin
					rsp.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < tbl_fill && key_order(tbl_key[pos]) < key_order(r.key))
						pos++;
					for (int i = tbl_fill; i > pos; i--) begin
						tbl_key[i] = tbl_key[i-1];
						tbl_data[i] = tbl_data[i-1];
					end
					tbl_key[pos] = r.key;
					tbl_data[pos] = r.data;
					tbl_fill++;
				end
			end
			REQ_DELETE: begin
				tbl_cursor = 0;
				pos = 0;
				while (pos < tbl_fill && tbl_key[pos] != r.key)
					pos++;
				if (pos == tbl_fill) begin
					rsp.status = ST_NOT_FOUND;
				end else begin
					rsp.data = tbl_data[pos];
					for (int i = pos; i + 1 < tbl_fill; i++) begin
						tbl_key[i] = tbl_key[i+1];
						tbl_data[i] = tbl_data[i+1];
					end
					tbl_fill--;
				end
			end
			REQ_ITER: begin
				if (tbl_cursor < tbl_fill) begin
					rsp.data = tbl_data[tbl_cursor];
					tbl_cursor++;
				end else begin
					rsp.status = ST_ITER_END;
					tbl_cursor = 0;
				end
			end
			default: begin
				tbl_fill = 0;
				tbl_cursor = 0;
			end
		endcase
		rsp.count = tbl_fill[8:0];
		return rsp;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] want);
		$display("mismatch on transfer %0d: %s got %h expected %h", got, what, seen, want);
		errors++;
	endtask

	function automatic void queue_req(req_t kind, logic [31:0] key, logic [31:0] data);
		pending_reqs.push_back('{kind, key, data});
	endfunction

	// Keys drawn from a small pool so deletes hit and duplicates occur.
	function automatic logic [31:0] pool_key();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 15);
			1: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
			2: return 32'h7FFF_FFF8 + $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: presents the oldest pending request and predicts on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				table_req_t acc;
				acc = pending_reqs.pop_front();
				expected_resps.push_back(table_apply(acc));
				sent++;
			end
			if ((!s_axis_tvalid || s_axis_tready) ) begin
				if (pending_reqs.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0) &&
				    pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {6'd0, pending_reqs[0].data, pending_reqs[0].key,
						pending_reqs[0].kind};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares every result transfer with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				table_resp_t rsp;
				table_resp_t want;
				rsp.status = status_t'(m_axis_tdata[1:0]);
				rsp.data   = m_axis_tdata[33:2];
				rsp.count  = m_axis_tdata[42:34];
				if (expected_resps.size() == 0) begin
					report_mismatch("unexpected result", rsp.data, 32'd0);
				end else begin
					want = expected_resps.pop_front();
					if (rsp.status != want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.data != want.data)
						report_mismatch("data_out", rsp.data, want.data);
					if (rsp.count != want.count)
						report_mismatch("entry_count", 32'(rsp.count), 32'(want.count));
				end
				got++;
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic drain();
		while (pending_reqs.size() != 0 || expected_resps.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_mode(logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cmp_signed = v;
	endtask

	initial begin
		int mode;
		int kind_pick;
		errors = 0; sent = 0; got = 0;
		tbl_fill = 0; tbl_cursor = 0; cmp_signed = 1'b0;
		send_idle_pct = 0; recv_stall_pct = 0;
		cfg_we = 1'b0; cfg_wdata = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty-table cases, extremes, duplicates and clear.
		queue_req(REQ_DELETE, 32'd5, 32'd0);
		queue_req(REQ_ITER, 32'd0, 32'd0);
		queue_req(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_req(REQ_INSERT, 32'd0, 32'd0);
		queue_req(REQ_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
		queue_req(REQ_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
		queue_req(REQ_INSERT, 32'd0, 32'd1);
		for (int i = 0; i < 6; i++)
			queue_req(REQ_ITER, 32'd0, 32'd0);
		queue_req(REQ_ITER, 32'd0, 32'd0);
		queue_req(REQ_DELETE, 32'd0, 32'd0);
		queue_req(REQ_DELETE, 32'd3, 32'd0);
		queue_req(REQ_ITER, 32'd0, 32'd0);
		queue_req(REQ_CLEAR, 32'd0, 32'd0);
		queue_req(REQ_ITER, 32'd0, 32'd0);
		drain();

		// Fill to capacity, overflow, and clear, in signed mode.
		write_mode(1'b1);
		for (int i = 0; i < CAPACITY + 2; i++)
			queue_req(REQ_INSERT, $urandom, $urandom);
		queue_req(REQ_ITER, 32'd0, 32'd0);
		queue_req(REQ_DELETE, 32'hFFFF_FFFF, 32'd0);
		queue_req(REQ_CLEAR, 32'd0, 32'd0);
		drain();

		// Random phases across idling patterns and both compare modes.
		for (int ph = 0; ph < 8; ph++) begin
			mode = ph % 4;
			send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 3) ? 19 : 70) : 0;
			recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 19 : 70) : 0;
			write_mode(ph[0]);
			for (int i = 0; i < 145; i++) begin
				kind_pick = $urandom_range(0, 99);
				if (kind_pick < 45)
					queue_req(REQ_INSERT, pool_key(), $urandom);
				else if (kind_pick < 70)
					queue_req(REQ_DELETE, pool_key(), $urandom);
				else if (kind_pick < 98)
					queue_req(REQ_ITER, $urandom, $urandom);
				else
					queue_req(REQ_CLEAR, $urandom, $urandom);
			end
			drain();
		end

		$display("Ran %0d requests, %0d results checked, both key compare modes,", sent, got);
		$display("empty and full table, duplicate keys, cursor wrap and stalled handshakes.");
		if (errors == 0 && expected_resps.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Generous bound on the whole run, sized for full-table shifts.
	initial begin
		#60ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
